// ===== rtl/ihfd_pkg.sv =====
package ihfd_pkg;

  // Framing bytes
  localparam logic [7:0] FRAME_HEAD  = 8'hA5;
  localparam logic [7:0] FRAME_START = 8'h5A;

  // Frame positions that are kept
  localparam logic [7:0] POS_LENGTH = 8'd0;
  localparam logic [7:0] POS_HIGH   = 8'd2;
  localparam logic [7:0] POS_LOW    = 8'd3;

  // Sign-magnitude layout of the heading word
  localparam int SIGN_POS = 15;

  // One processed byte: whether it closes a frame, and the decoded heading
  typedef struct packed {
    logic               emit;
    logic signed [15:0] heading;
  } ihfd_result_t;

  // Sign-magnitude to two's complement; negative zero maps to zero
  function automatic logic signed [15:0] decode_heading(input logic [7:0] hi,
                                                        input logic [7:0] lo);
    logic [15:0] raw;
    logic [15:0] mag;
    logic [15:0] val;
    raw = {hi, lo};
    mag = {1'b0, raw[SIGN_POS-1:0]};
    val = raw[SIGN_POS] ? (16'd0 - mag) : mag;
    return signed'(val);
  endfunction

endpackage

// ===== rtl/ihfd_frame.sv =====
module ihfd_frame (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              rx_byte,
  output ihfd_pkg::ihfd_result_t  res
);
  import ihfd_pkg::*;

  logic       head_seen;
  logic [7:0] write_index;
  logic [7:0] frame_length;
  logic [7:0] heading_high;
  logic [7:0] heading_low;

  logic       head_seen_next;
  logic [7:0] write_index_next;
  logic [7:0] frame_length_next;
  logic [7:0] heading_high_next;
  logic [7:0] heading_low_next;

  logic       is_head;
  logic       is_start;
  logic       do_store;
  logic [7:0] index_inc;

  // Byte classification and the store into the kept positions
  always_comb begin
    is_head   = (rx_byte == FRAME_HEAD);
    is_start  = (rx_byte == FRAME_START);
    // a start byte right after a head byte opens a frame instead of storing
    do_store  = is_head || !is_start || !head_seen;
    index_inc = write_index + 8'd1;

    frame_length_next = (do_store && write_index == POS_LENGTH) ? rx_byte : frame_length;
    heading_high_next = (do_store && write_index == POS_HIGH)   ? rx_byte : heading_high;
    heading_low_next  = (do_store && write_index == POS_LOW)    ? rx_byte : heading_low;

    head_seen_next   = is_head;
    write_index_next = do_store ? index_inc : 8'd0;
    res.emit         = 1'b0;
    // only data bytes are checked against the length
    if (!is_head && !is_start && index_inc == frame_length_next) begin
      res.emit         = 1'b1;
      write_index_next = 8'd0;
    end
    res.heading = decode_heading(heading_high_next, heading_low_next);
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_seen    <= 1'b0;
      write_index  <= 8'd0;
      frame_length <= 8'd0;
      heading_high <= 8'd0;
      heading_low  <= 8'd0;
    end else if (step) begin
      head_seen    <= head_seen_next;
      write_index  <= write_index_next;
      frame_length <= frame_length_next;
      heading_high <= heading_high_next;
      heading_low  <= heading_low_next;
    end
  end

`ifndef SYNTH
  // A frame end always returns the index to the frame start
  a_emit_clears_index: assert property (@(posedge clk) disable iff (rst)
    (step && res.emit) |=> (write_index == 8'd0))
    else $error("index not cleared after frame end");

  // A start pair clears the index and the head flag
  a_start_pair: assert property (@(posedge clk) disable iff (rst)
    (step && head_seen && rx_byte == FRAME_START) |=> (write_index == 8'd0 && !head_seen))
    else $error("start pair not handled");

  // The head flag tracks the last processed byte
  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    step |=> (head_seen == ($past(rx_byte) == FRAME_HEAD)))
    else $error("head flag mismatch");
`endif

endmodule

// ===== rtl/ihfd_out_reg.sv =====
module ihfd_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  ihfd_pkg::ihfd_result_t  res,
  output logic                    room,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [15:0]      heading
);
  import ihfd_pkg::*;

  // Free now, or freed by the receiver at this edge
  assign room = !out_valid || out_ready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load && res.emit) begin
      heading <= res.heading;
    end
  end

`ifndef SYNTH
  // A result is only written when the register has room
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    (load && res.emit) |-> room)
    else $error("result written over a pending result");
`endif

endmodule

// ===== rtl/imu_heading_frame_decoder.sv =====
// Heading frame decoder.
// Input channel: rx_byte with in_valid / in_ready, one received byte per item.
// Output channel: heading with out_valid / out_ready, one item per completed
// frame (sign-magnitude bytes two and three as a signed 16-bit value).
// A byte pair 0xA5, 0x5A starts a frame; the byte at position 0 is the length.
// Path: an accepted byte waits in the input register, is decoded from there, and
// its heading is loaded into the result register, which offers it on the output.
// Throughput: one byte per cycle while no result waits on out_ready, set by the
// input register feeding the single decode stage and the result register.
// Stall: the input register holds one byte while a result waits; the decode
// stage advances only when the result register is empty or being read, so
// in_ready drops after one more byte when the receiver holds out_ready low.
// Reset (rst, synchronous): clears the frame index, length, heading bytes and
// the head flag, and empties both registers.
module imu_heading_frame_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] heading
);
  import ihfd_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         room;
  logic         advance;
  ihfd_result_t res;

  assign advance  = s1_valid && room;
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  ihfd_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (s1_byte),
    .res     (res)
  );

  ihfd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .heading   (heading)
  );

`ifndef SYNTH
  // A held byte is never dropped while the decode stage is blocked
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !room) |=> (s1_valid && $stable(s1_byte)))
    else $error("pending byte lost");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ihfd_pkg::*;

  localparam int ITEM_TARGET = 1550;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] heading;

  // Idle / stall enables for each side
  bit in_gaps_on   = 1'b1;
  bit out_stall_on = 1'b1;

  int items_sent = 0;
  int errors     = 0;

  // Expected headings, oldest first
  logic signed [15:0] exp_heading_q[$];
  logic signed [15:0] want_heading;

  // Shadow frame state
  bit         frame_head_seen;
  logic [7:0] frame_idx;
  logic [7:0] frame_len;
  logic [7:0] hdg_hi;
  logic [7:0] hdg_lo;

  imu_heading_frame_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .heading   (heading)
  );

  always #10 clk = ~clk;

  // Sign-magnitude heading word to two's complement; negative zero gives zero
  function automatic logic signed [15:0] sm_to_heading(input logic [7:0] hi,
                                                       input logic [7:0] lo);
    logic [15:0] mag;
    mag = {1'b0, hi[6:0], lo};
    return hi[7] ? $signed(16'd0 - mag) : $signed(mag);
  endfunction

  // Only length and heading positions are kept; index always advances
  function void store_frame_byte(input logic [7:0] b);
    case (frame_idx)
      POS_LENGTH: frame_len = b;
      POS_HIGH:   hdg_hi = b;
      POS_LOW:    hdg_lo = b;
      default: ;
    endcase
    frame_idx = frame_idx + 8'd1;
  endfunction

  // Advance the shadow state by one accepted byte
  function void track_byte(input logic [7:0] b);
    if (b == FRAME_HEAD) begin
      frame_head_seen = 1'b1;
      store_frame_byte(b);
    end else if (b == FRAME_START) begin
      if (frame_head_seen) begin
        frame_idx = 8'd0;
      end else begin
        store_frame_byte(b);
      end
      frame_head_seen = 1'b0;
    end else begin
      store_frame_byte(b);
      frame_head_seen = 1'b0;
      if (frame_idx == frame_len) begin
        exp_heading_q.push_back(sm_to_heading(hdg_hi, hdg_lo));
        frame_idx = 8'd0;
      end
    end
  endfunction

  // Random byte that is neither framing byte
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == FRAME_HEAD || b == FRAME_START);
    return b;
  endfunction

  // Offer one byte, wait for it to be taken; called and returns at falling edge
  task automatic send_byte(input logic [7:0] b);
    while (in_gaps_on && $urandom_range(0, 99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    track_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  // Start pair, length, then the rest of the frame body
  task automatic send_frame(input logic [7:0] len, input bit clean, input int body);
    logic [7:0] b;
    send_byte(FRAME_HEAD);
    send_byte(FRAME_START);
    send_byte(len);
    for (int i = 1; i < body; i++) begin
      b = clean ? plain_byte() : 8'($urandom);
      send_byte(b);
    end
  endtask

  // Hold the input off until every expected heading has arrived
  task automatic drain_results();
    in_valid = 1'b0;
    while (exp_heading_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Extremes of the sign-magnitude decode
  task automatic test_sign_magnitude();
    logic [7:0] words[4][2] = '{'{8'h7F, 8'hFF}, '{8'hFF, 8'hFF},
                                '{8'h80, 8'h00}, '{8'h00, 8'h01}};
    foreach (words[i]) begin
      send_byte(FRAME_HEAD);
      send_byte(FRAME_START);
      send_byte(8'd4);
      send_byte(8'($urandom));
      send_byte(words[i][0]);
      send_byte(words[i][1]);
    end
  endtask

  // Repeated head byte, length of one, length hit by framing bytes, lone start byte
  task automatic test_framing_corners();
    send_byte(FRAME_HEAD);
    send_byte(FRAME_HEAD);
    send_byte(FRAME_START);
    send_byte(8'd1);
    send_byte(FRAME_HEAD);
    send_byte(FRAME_START);
    send_byte(8'd3);
    send_byte(FRAME_START);
    send_byte(FRAME_HEAD);
    send_byte(8'h00);
  endtask

  // Length zero only completes when the index wraps back to position 0
  task automatic test_index_wrap();
    send_byte(FRAME_HEAD);
    send_byte(FRAME_START);
    send_byte(8'd0);
    for (int i = 0; i < 255; i++) send_byte(plain_byte());
  endtask

  // Long stretch with no gaps and no stalls
  task automatic test_back_to_back();
    int len;
    in_gaps_on   = 1'b0;
    out_stall_on = 1'b0;
    repeat (40) begin
      len = $urandom_range(1, 6);
      send_frame(8'(len), 1'b1, len);
    end
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
  endtask

  // Mostly clean frames with random content, plus broken frames and noise
  task automatic test_random_traffic();
    int         pick;
    int         len;
    logic [7:0] b;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        len = ($urandom_range(0, 99) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 8);
        send_frame(8'(len), 1'b1, len);
      end else if (pick < 88) begin
        len = $urandom_range(0, 12);
        send_frame(8'(len), 1'b0, $urandom_range(0, len + 2));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: b = FRAME_HEAD;
            1: b = FRAME_START;
            default: b = 8'($urandom);
          endcase
          send_byte(b);
        end
      end
      if ($urandom_range(0, 199) == 0) drain_results();
    end
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= !(out_stall_on && $urandom_range(0, 99) < 7);
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_heading_q.size() == 0) begin
        $error("unexpected item: heading %0d", heading);
        errors++;
      end else begin
        want_heading = exp_heading_q.pop_front();
        if (heading !== want_heading) begin
          $error("heading mismatch: expected %0d, actual %0d", want_heading, heading);
          errors++;
        end
      end
    end
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    frame_head_seen = 1'b0;
    frame_idx       = 8'd0;
    frame_len       = 8'd0;
    hdg_hi          = 8'd0;
    hdg_lo          = 8'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_sign_magnitude();
    test_framing_corners();
    drain_results();
    test_index_wrap();
    test_back_to_back();
    drain_results();
    test_random_traffic();

    in_valid = 1'b0;
    while (exp_heading_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (exp_heading_q.size() != 0) begin
      $error("%0d expected headings never arrived", exp_heading_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
